FILE: rtl/nspc_pkg.sv
// package for the nearest scaler pixel convert unit
// holds sizes, command, mode and register codes, and the pixel conversion functions
`default_nettype none
package nspc_pkg;
	localparam int SRC_MAX_W = 256;
	localparam int SRC_MAX_H = 256;
	localparam int VIEW_MAX  = 1024;
	localparam int FS_DEPTH  = SRC_MAX_W * SRC_MAX_H;
	localparam int FS_AW     = $clog2(FS_DEPTH);
	localparam int SW_W      = $clog2(SRC_MAX_W + 1);
	localparam int SH_W      = $clog2(SRC_MAX_H + 1);
	localparam int VW_W      = $clog2(VIEW_MAX + 1);
	localparam int QX_W      = $clog2(SRC_MAX_W);
	localparam int QY_W      = $clog2(SRC_MAX_H);
	localparam int QN        = (QX_W > QY_W) ? QX_W : QY_W;
	localparam int PX_W      = 10 + SW_W;
	localparam int PY_W      = 10 + SH_W;
	localparam int DV_W      = ((PX_W > PY_W) ? PX_W : PY_W) + 1;

	typedef enum logic [1:0] {
		CMD_WR_PIX = 2'd0,
		CMD_WR_PAL = 2'd1,
		CMD_RD     = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_PEN8     = 3'd0,
		MODE_565_332  = 3'd1,
		MODE_888_332  = 3'd2,
		MODE_LUT8     = 3'd3,
		MODE_565_XRGB = 3'd4,
		MODE_PASS     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		REG_SRC_W  = 3'd0,
		REG_SRC_H  = 3'd1,
		REG_VIEW_W = 3'd2,
		REG_VIEW_H = 3'd3,
		REG_MODE   = 3'd4,
		REG_USE_PAL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        oor;
		logic [FS_AW-1:0] addr;
		logic [31:0] data;
	} item_t;

	function automatic logic [7:0] rgb332_16(input logic [15:0] c);
		logic [7:0] r;
		r = {c[15:13], c[10:8], c[4:3]};
		return r;
	endfunction

	function automatic logic [7:0] rgb332_32(input logic [31:0] c);
		logic [7:0] r;
		r = {c[23:21], c[15:13], c[7:6]};
		return r;
	endfunction

	function automatic logic [31:0] xrgb_565(input logic [15:0] c);
		logic [31:0] r;
		r = {8'h00, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/nearest_scaler_pixel_convert_unit.sv
// nearest neighbor scaler with pixel conversion: frame store, palette and pipelined divider
// depends on nspc_pkg
`default_nettype none
// only reads produce a result transfer; writes and nops leave no result
// throughput: one item per cycle; the pipeline stalls as a whole only while a result waits
// pipeline: product, 8 divider bit stages, address multiply, frame store read, palette read, output
// frame store and palette are written at the same stage where they are read, so order holds
// reset clears valid bits and config registers; the memories have no reset and no clearing pass
module nearest_scaler_pixel_convert_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // addr[15:0], data[47:16], view_x[57:48], view_y[67:58], zero
	input  wire logic [1:0]  s_tuser,   // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // pixel_out
	output logic             m_tuser    // out_of_range
);
	import nspc_pkg::*;

	localparam int NS = QN + 1; // s1 plus divider stages

	// configuration
	logic [8:0]  src_w_q, src_h_q;
	logic [10:0] view_w_q, view_h_q;
	mode_t       mode_q;
	logic        use_pal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= 9'd256;
			src_h_q   <= 9'd256;
			view_w_q  <= 11'd256;
			view_h_q  <= 11'd256;
			mode_q    <= MODE_PEN8;
			use_pal_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_W:   src_w_q   <= cfg_data[8:0];
				REG_SRC_H:   src_h_q   <= cfg_data[8:0];
				REG_VIEW_W:  view_w_q  <= cfg_data;
				REG_VIEW_H:  view_h_q  <= cfg_data;
				REG_MODE:    mode_q    <= mode_t'(cfg_data[2:0]);
				REG_USE_PAL: use_pal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturated sizes
	logic [SW_W-1:0] sw;
	logic [SH_W-1:0] sh;
	logic [VW_W-1:0] vw, vh;
	assign sw = (32'(src_w_q) > SRC_MAX_W) ? SW_W'(SRC_MAX_W) : SW_W'(src_w_q);
	assign sh = (32'(src_h_q) > SRC_MAX_H) ? SH_W'(SRC_MAX_H) : SH_W'(src_h_q);
	assign vw = (32'(view_w_q) > VIEW_MAX) ? VW_W'(VIEW_MAX) : VW_W'(view_w_q);
	assign vh = (32'(view_h_q) > VIEW_MAX) ? VW_W'(VIEW_MAX) : VW_W'(view_h_q);

	// input unpack
	logic [15:0] in_addr;
	logic [31:0] in_data;
	logic [9:0]  in_vx, in_vy;
	assign in_addr = s_tdata[15:0];
	assign in_data = s_tdata[47:16];
	assign in_vx   = s_tdata[57:48];
	assign in_vy   = s_tdata[67:58];

	// whole pipeline moves when the output register is free or being taken
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1 and divider stages, index 0 is s1
	logic            val_s [NS];
	item_t           itm_s [NS];
	logic [DV_W-1:0] remx_s [NS];
	logic [DV_W-1:0] remy_s [NS];
	logic [QN-1:0]   qx_s [NS];
	logic [QN-1:0]   qy_s [NS];

	// address, frame read, palette read, output
	logic        val_s10, val_s11, val_s12;
	item_t       itm_s10, itm_s11, itm_s12;
	logic [31:0] pix_s11, pix_s12;
	logic [7:0]  pre_s12;
	logic [31:0] pal_s12;

	logic [31:0] fs_mem [FS_DEPTH];
	logic [31:0] pal_mem [256];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++) val_s[j] <= 1'b0;
			val_s10  <= 1'b0;
			val_s11  <= 1'b0;
			val_s12  <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			val_s[0] <= s_tvalid && (cmd_t'(s_tuser) != CMD_NOP);
			for (int j = 1; j < NS; j++) val_s[j] <= val_s[j-1];
			val_s10  <= val_s[NS-1];
			val_s11  <= val_s10;
			val_s12  <= val_s11;
			m_tvalid <= val_s12 && (itm_s12.cmd == CMD_RD);
		end
	end

	// reads carry the frame store address in place of the command address
	item_t itm_nx10;
	always_comb begin
		itm_nx10 = itm_s[NS-1];
		if (itm_s[NS-1].cmd == CMD_RD)
			itm_nx10.addr = FS_AW'(qy_s[NS-1] * sw + 32'(qx_s[NS-1]));
	end

	logic [7:0] pre8;
	logic [7:0] pal_idx;
	always_comb begin
		case (mode_q)
			MODE_565_332: pre8 = rgb332_16(pix_s11[15:0]);
			MODE_888_332: pre8 = rgb332_32(pix_s11);
			default:      pre8 = pix_s11[7:0];
		endcase
		pal_idx = (mode_q == MODE_LUT8) ? pix_s11[7:0] : pre8;
	end

	logic [31:0] pix_out;
	always_comb begin
		case (mode_q)
			MODE_PEN8, MODE_565_332, MODE_888_332:
				pix_out = {24'h0, use_pal_q ? pal_s12[7:0] : pre_s12};
			MODE_LUT8:     pix_out = pal_s12;
			MODE_565_XRGB: pix_out = xrgb_565(pix_s12[15:0]);
			MODE_PASS:     pix_out = pix_s12;
			default:       pix_out = 32'h0;
		endcase
		if (itm_s12.oor) pix_out = 32'h0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: products for both axes
			itm_s[0].cmd  <= cmd_t'(s_tuser);
			itm_s[0].oor  <= (VW_W'(in_vx) >= vw) || (VW_W'(in_vy) >= vh) ||
				(32'(in_vx) >= VIEW_MAX) || (32'(in_vy) >= VIEW_MAX);
			itm_s[0].addr <= FS_AW'(in_addr);
			itm_s[0].data <= in_data;
			remx_s[0] <= DV_W'(in_vx) * DV_W'(sw);
			remy_s[0] <= DV_W'(in_vy) * DV_W'(sh);
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			// restoring division, one quotient bit per stage
			for (int j = 1; j < NS; j++) begin
				itm_s[j] <= itm_s[j-1];
				if (remx_s[j-1] >= (DV_W'(vw) << (QN - j))) begin
					remx_s[j] <= remx_s[j-1] - (DV_W'(vw) << (QN - j));
					qx_s[j]   <= {qx_s[j-1][QN-2:0], 1'b1};
				end else begin
					remx_s[j] <= remx_s[j-1];
					qx_s[j]   <= {qx_s[j-1][QN-2:0], 1'b0};
				end
				if (remy_s[j-1] >= (DV_W'(vh) << (QN - j))) begin
					remy_s[j] <= remy_s[j-1] - (DV_W'(vh) << (QN - j));
					qy_s[j]   <= {qy_s[j-1][QN-2:0], 1'b1};
				end else begin
					remy_s[j] <= remy_s[j-1];
					qy_s[j]   <= {qy_s[j-1][QN-2:0], 1'b0};
				end
			end
			// s10: frame store address
			itm_s10 <= itm_nx10;
			// s11: frame store read or write
			itm_s11 <= itm_s10;
			if (val_s10 && itm_s10.cmd == CMD_WR_PIX)
				fs_mem[itm_s10.addr] <= itm_s10.data;
			pix_s11 <= fs_mem[itm_s10.addr];
			// s12: palette read or write
			itm_s12 <= itm_s11;
			pix_s12 <= pix_s11;
			pre_s12 <= pre8;
			if (val_s11 && itm_s11.cmd == CMD_WR_PAL)
				pal_mem[itm_s11.addr[7:0]] <= itm_s11.data;
			pal_s12 <= pal_mem[pal_idx];
			// output register
			m_tdata <= pix_out;
			m_tuser <= itm_s12.oor;
		end
	end

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'h0) else $error("out of range pixel not zero");
	a_pen_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (mode_q == MODE_PEN8 || mode_q == MODE_565_332 || mode_q == MODE_888_332)
		|-> m_tdata[31:8] == 24'h0) else $error("pen result wider than 8 bits");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		val_s[NS-1] && itm_s[NS-1].cmd == CMD_RD && !itm_s[NS-1].oor && sw != '0
		|-> 32'(qx_s[NS-1]) < 32'(sw)) else $error("source column beyond width");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready)) else $error("ready does not follow output stage");
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for nearest_scaler_pixel_convert_unit: directed rows, then random phases
// each phase sets the scaler registers, then streams writes and reads checked against a local predictor
// depends on nspc_pkg and the rtl of the unit
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nspc_pkg::*;

	// expected read result, one per read transfer
	typedef struct {
		logic [31:0] pix;
		logic        oor;
	} px_result_t;

	// one directed input row; known marks rows whose result is typed in
	typedef struct {
		cmd_t        cmd;
		logic [15:0] addr;
		logic [31:0] data;
		logic [9:0]  vx;
		logic [9:0]  vy;
		bit          known;
		logic [31:0] pix;
		logic        oor;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // addr[15:0], data[47:16], view_x[57:48], view_y[67:58], zero
	logic [1:0]  s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // pixel_out
	logic        m_tuser;   // out_of_range

	// predictor copy of the registers and both stores
	logic [8:0]  src_w_reg, src_h_reg;
	logic [10:0] view_w_reg, view_h_reg;
	logic [2:0]  mode_reg;
	logic        pal_en_reg;
	logic [31:0] frame_mem [FS_DEPTH];
	logic [31:0] pal_mem [256];
	bit          frame_written [FS_DEPTH];

	px_result_t  pending_px [$];
	int          err_count = 0;
	int          burst_left = 0;
	int          rdy_cycle = 0;
	int          rdy_style = 0;

	// directed rows under the reset settings: 256x256 source, 256x256 view, pen8, no palette
	stim_row_t dir_rows [14] = '{
		'{CMD_WR_PIX, 16'h0000, 32'hdeadbeef, 10'd0,    10'd0,    1'b0, 32'h0,  1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd0,    10'd0,    1'b1, 32'hef, 1'b0},
		'{CMD_WR_PIX, 16'hffff, 32'h12345678, 10'd0,    10'd0,    1'b0, 32'h0,  1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd255,  10'd255,  1'b1, 32'h78, 1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd256,  10'd0,    1'b1, 32'h0,  1'b1},
		'{CMD_RD,     16'h0000, 32'h0,        10'd0,    10'd256,  1'b1, 32'h0,  1'b1},
		'{CMD_RD,     16'hffff, 32'hffffffff, 10'd1023, 10'd1023, 1'b1, 32'h0,  1'b1},
		'{CMD_WR_PAL, 16'h01ff, 32'ha5a5a5a5, 10'd0,    10'd0,    1'b0, 32'h0,  1'b0},
		'{CMD_NOP,    16'hffff, 32'hffffffff, 10'd1023, 10'd1023, 1'b0, 32'h0,  1'b0},
		'{CMD_WR_PIX, 16'h0101, 32'h000000ff, 10'd0,    10'd0,    1'b0, 32'h0,  1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd1,    10'd1,    1'b1, 32'hff, 1'b0},
		'{CMD_WR_PIX, 16'h8080, 32'h55aa33cc, 10'd0,    10'd0,    1'b0, 32'h0,  1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd128,  10'd128,  1'b1, 32'hcc, 1'b0},
		'{CMD_RD,     16'h0000, 32'h0,        10'd255,  10'd255,  1'b0, 32'h0,  1'b0}
	};

	nearest_scaler_pixel_convert_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// frame store address that a view pixel maps to under the current registers
	function automatic int unsigned view_to_addr(logic [9:0] vx, logic [9:0] vy);
		int unsigned sw, sh, vw, vh, sx, sy;
		sw = (src_w_reg > SRC_MAX_W) ? SRC_MAX_W : src_w_reg;
		sh = (src_h_reg > SRC_MAX_H) ? SRC_MAX_H : src_h_reg;
		vw = (view_w_reg > VIEW_MAX) ? VIEW_MAX : view_w_reg;
		vh = (view_h_reg > VIEW_MAX) ? VIEW_MAX : view_h_reg;
		sx = (vw == 0) ? 0 : (vx * sw) / vw;
		sy = (vh == 0) ? 0 : (vy * sh) / vh;
		return (sy * sw + sx) % FS_DEPTH;
	endfunction

	function automatic bit view_outside(logic [9:0] vx, logic [9:0] vy);
		int unsigned vw, vh;
		vw = (view_w_reg > VIEW_MAX) ? VIEW_MAX : view_w_reg;
		vh = (view_h_reg > VIEW_MAX) ? VIEW_MAX : view_h_reg;
		return (vx >= vw) || (vy >= vh);
	endfunction

	// 8-bit value, optionally replaced by the low byte of its palette entry
	function automatic logic [31:0] pen_lookup(logic [7:0] v);
		return pal_en_reg ? {24'h0, pal_mem[v][7:0]} : {24'h0, v};
	endfunction

	function automatic logic [31:0] convert_pixel(logic [31:0] p);
		logic [31:0] c16;
		c16 = {16'h0, p[15:0]};
		case (mode_reg)
			MODE_PEN8:     return pen_lookup(p[7:0]);
			MODE_565_332:  return pen_lookup(8'(((c16 >> 8) & 32'he0) + ((c16 >> 6) & 32'h1c)
				+ ((c16 >> 3) & 32'h03)));
			MODE_888_332:  return pen_lookup(8'(((p >> 16) & 32'he0) + ((p >> 11) & 32'h1c)
				+ ((p >> 6) & 32'h03)));
			MODE_LUT8:     return pal_mem[p[7:0]];
			MODE_565_XRGB: return ((c16 << 8) & 32'hf80000) + ((c16 << 5) & 32'hfc00)
				+ ((c16 << 3) & 32'hff);
			MODE_PASS:     return p;
			default:       return 32'h0;
		endcase
	endfunction

	function automatic px_result_t scaled_pixel(logic [9:0] vx, logic [9:0] vy);
		px_result_t r;
		if (view_outside(vx, vy)) begin
			r.pix = 32'h0;
			r.oor = 1'b1;
		end else begin
			r.pix = convert_pixel(frame_mem[view_to_addr(vx, vy)]);
			r.oor = 1'b0;
		end
		return r;
	endfunction

	// register write; only called while nothing is in flight
	task automatic write_reg(reg_idx_t idx, logic [10:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_SRC_W:   src_w_reg  = value[8:0];
			REG_SRC_H:   src_h_reg  = value[8:0];
			REG_VIEW_W:  view_w_reg = value;
			REG_VIEW_H:  view_h_reg = value;
			REG_MODE:    mode_reg   = value[2:0];
			REG_USE_PAL: pal_en_reg = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pacing: bursts of random length with random gaps between them
	task automatic pace_sender();
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// present one item, wait for its transfer, then update the predictor
	task automatic send_item(cmd_t cmd, logic [15:0] addr, logic [31:0] data, logic [9:0] vx,
		logic [9:0] vy, bit known, logic [31:0] kpix, logic koor);
		px_result_t r;
		pace_sender();
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'h0, vy, vx, data, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (cmd)
			CMD_WR_PIX: begin
				frame_mem[addr]     = data;
				frame_written[addr] = 1'b1;
			end
			CMD_WR_PAL: begin
				pal_mem[addr[7:0]] = data;
			end
			CMD_RD: begin
				if (known) begin
					r.pix = kpix;
					r.oor = koor;
				end else begin
					r = scaled_pixel(vx, vy);
				end
				pending_px.push_back(r);
			end
			default: ;
		endcase
	endtask

	// a read of random content; the mapped source pixel is written first if it never was
	task automatic random_read(int unsigned vx_lim, int unsigned vy_lim);
		logic [9:0]  vx, vy;
		int unsigned a;
		if ($urandom_range(0, 15) == 0) begin
			vx = 10'($urandom);
			vy = 10'($urandom);
		end else begin
			vx = 10'($urandom_range(0, vx_lim));
			vy = 10'($urandom_range(0, vy_lim));
		end
		if (!view_outside(vx, vy)) begin
			a = view_to_addr(vx, vy);
			if (!frame_written[a])
				send_item(CMD_WR_PIX, 16'(a), $urandom, 10'($urandom), 10'($urandom), 1'b0,
					32'h0, 1'b0);
		end
		send_item(CMD_RD, 16'($urandom), $urandom, vx, vy, 1'b0, 32'h0, 1'b0);
	endtask

	// let the pipeline drain before any register write
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver stalls on its own pattern: always ready, coin flip, or mostly stalled
	always @(posedge clk) begin
		if (rdy_cycle % 300 == 0)
			rdy_style = $urandom_range(0, 2);
		rdy_cycle++;
		case (rdy_style)
			0:       m_tready <= 1'b1;
			1:       m_tready <= $urandom_range(0, 1);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result checker: each result transfer against the oldest expectation
	always @(posedge clk) begin
		px_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected result pixel %h oor %b", $realtime, m_tdata, m_tuser);
				err_count++;
			end else begin
				e = pending_px.pop_front();
				if (m_tdata !== e.pix) begin
					$display("%0t: pixel expected %h actual %h", $realtime, e.pix, m_tdata);
					err_count++;
				end
				if (m_tuser !== e.oor) begin
					$display("%0t: out_of_range expected %b actual %b", $realtime, e.oor, m_tuser);
					err_count++;
				end
			end
		end
	end

	// run limit far above the slowest correct run
	initial begin
		#3ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned sw, sh, vw, vh, vx_lim, vy_lim, pick;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_NOP;
		src_w_reg  = 9'd256;
		src_h_reg  = 9'd256;
		view_w_reg = 11'd256;
		view_h_reg = 11'd256;
		mode_reg   = MODE_PEN8;
		pal_en_reg = 1'b0;
		arst_n     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].vx,
				dir_rows[i].vy, dir_rows[i].known, dir_rows[i].pix, dir_rows[i].oor);

		// fill the whole palette so later lookups only hit written entries
		for (int i = 0; i < 256; i++)
			send_item(CMD_WR_PAL, {8'($urandom_range(0, 255)), 8'(i)}, $urandom,
				10'($urandom), 10'($urandom), 1'b0, 32'h0, 1'b0);

		// sixteen phases: every mode with and without the palette pen
		for (int ph = 0; ph < 16; ph++) begin
			drain();
			case (ph)
				0: begin sw = 1;   sh = 1;   vw = 1;    vh = 1;    end
				1: begin sw = 256; sh = 256; vw = 1024; vh = 1024; end
				2: begin sw = 511; sh = 511; vw = 2047; vh = 2047; end  // saturate
				3: begin sw = 0;   sh = 0;   vw = 1024; vh = 700;  end  // zero source size
				4: begin sw = 40;  sh = 30;  vw = 0;    vh = 0;    end  // zero view size
				5: begin sw = 256; sh = 256; vw = 1;    vh = 3;    end
				default: begin
					sw = $urandom_range(1, 256);
					sh = $urandom_range(1, 256);
					vw = $urandom_range(1, 1024);
					vh = $urandom_range(1, 1024);
				end
			endcase
			write_reg(REG_SRC_W, 11'(sw));
			write_reg(REG_SRC_H, 11'(sh));
			write_reg(REG_VIEW_W, 11'(vw));
			write_reg(REG_VIEW_H, 11'(vh));
			write_reg(REG_MODE, 11'(ph % 8));
			write_reg(REG_USE_PAL, 11'(ph / 8));
			vw = (vw > VIEW_MAX) ? VIEW_MAX : vw;
			vh = (vh > VIEW_MAX) ? VIEW_MAX : vh;
			vx_lim = (vw + vw / 8 + 1 > 1023) ? 1023 : vw + vw / 8 + 1;
			vy_lim = (vh + vh / 8 + 1 > 1023) ? 1023 : vh + vh / 8 + 1;
			for (int n = 0; n < 35; n++) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					random_read(vx_lim, vy_lim);
				else if (pick < 17)
					send_item(CMD_WR_PIX, 16'($urandom), $urandom, 10'($urandom),
						10'($urandom), 1'b0, 32'h0, 1'b0);
				else if (pick < 19)
					send_item(CMD_WR_PAL, 16'($urandom), $urandom, 10'($urandom),
						10'($urandom), 1'b0, 32'h0, 1'b0);
				else
					send_item(CMD_NOP, 16'($urandom), $urandom, 10'($urandom),
						10'($urandom), 1'b0, 32'h0, 1'b0);
			end
		end

		drain();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/nspc_pkg.sv
rtl/nearest_scaler_pixel_convert_unit.sv
tb/sv/tb_top.sv
